>>> sv/oems_pkg.sv
// oems_pkg: shared types, codes and the control program of the odd-even merge sorter
// no dependencies; imported by odd_even_merge_sorter_unit and the testbench
package oems_pkg;

  // port widths that the interface fixes
  localparam int DATA_W = 32;
  localparam int POS_W  = 6;

  // micro-operation codes, one datapath action per control word
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP    = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 4'd1;
  localparam logic [OP_W-1:0] OP_P_INIT = 4'd2;
  localparam logic [OP_W-1:0] OP_K_INIT = 4'd3;
  localparam logic [OP_W-1:0] OP_J_INIT = 4'd4;
  localparam logic [OP_W-1:0] OP_I_INIT = 4'd5;
  localparam logic [OP_W-1:0] OP_READ   = 4'd6;
  localparam logic [OP_W-1:0] OP_SWAP_A = 4'd7;
  localparam logic [OP_W-1:0] OP_SWAP_B = 4'd8;
  localparam logic [OP_W-1:0] OP_I_NEXT = 4'd9;
  localparam logic [OP_W-1:0] OP_J_NEXT = 4'd10;
  localparam logic [OP_W-1:0] OP_K_NEXT = 4'd11;
  localparam logic [OP_W-1:0] OP_P_NEXT = 4'd12;
  localparam logic [OP_W-1:0] OP_O_INIT = 4'd13;
  localparam logic [OP_W-1:0] OP_E_READ = 4'd14;
  localparam logic [OP_W-1:0] OP_EMIT   = 4'd15;

  // hold conditions: the step waits, and does nothing, while its hold is true
  localparam int HOLD_W = 2;
  localparam logic [HOLD_W-1:0] HOLD_NONE = 2'd0;
  localparam logic [HOLD_W-1:0] HOLD_IN   = 2'd1;
  localparam logic [HOLD_W-1:0] HOLD_OUT  = 2'd2;

  // jump conditions, taken to the target when true
  localparam int JUMP_W = 4;
  localparam logic [JUMP_W-1:0] JUMP_NEVER     = 4'd0;
  localparam logic [JUMP_W-1:0] JUMP_ALWAYS    = 4'd1;
  localparam logic [JUMP_W-1:0] JUMP_LOAD_MORE = 4'd2;
  localparam logic [JUMP_W-1:0] JUMP_P_END     = 4'd3;
  localparam logic [JUMP_W-1:0] JUMP_K_END     = 4'd4;
  localparam logic [JUMP_W-1:0] JUMP_J_END     = 4'd5;
  localparam logic [JUMP_W-1:0] JUMP_I_END     = 4'd6;
  localparam logic [JUMP_W-1:0] JUMP_CROSS     = 4'd7;
  localparam logic [JUMP_W-1:0] JUMP_EMIT_MORE = 4'd8;

  // program addresses
  localparam int UPC_W = 5;
  localparam logic [UPC_W-1:0] STEP_LOAD   = 5'd0;
  localparam logic [UPC_W-1:0] STEP_P_INIT = 5'd1;
  localparam logic [UPC_W-1:0] STEP_P_TEST = 5'd2;
  localparam logic [UPC_W-1:0] STEP_K_INIT = 5'd3;
  localparam logic [UPC_W-1:0] STEP_K_TEST = 5'd4;
  localparam logic [UPC_W-1:0] STEP_J_INIT = 5'd5;
  localparam logic [UPC_W-1:0] STEP_J_TEST = 5'd6;
  localparam logic [UPC_W-1:0] STEP_I_INIT = 5'd7;
  localparam logic [UPC_W-1:0] STEP_I_TEST = 5'd8;
  localparam logic [UPC_W-1:0] STEP_READ   = 5'd9;
  localparam logic [UPC_W-1:0] STEP_SWAP_A = 5'd10;
  localparam logic [UPC_W-1:0] STEP_SWAP_B = 5'd11;
  localparam logic [UPC_W-1:0] STEP_I_NEXT = 5'd12;
  localparam logic [UPC_W-1:0] STEP_J_NEXT = 5'd13;
  localparam logic [UPC_W-1:0] STEP_K_NEXT = 5'd14;
  localparam logic [UPC_W-1:0] STEP_P_NEXT = 5'd15;
  localparam logic [UPC_W-1:0] STEP_O_INIT = 5'd16;
  localparam logic [UPC_W-1:0] STEP_E_READ = 5'd17;
  localparam logic [UPC_W-1:0] STEP_EMIT   = 5'd18;
  localparam logic [UPC_W-1:0] STEP_BACK   = 5'd19;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [HOLD_W-1:0] hold;
    logic [JUMP_W-1:0] jump;
    logic [UPC_W-1:0]  target;
  } ctrl_word_t;

  // control store: the loop nest of the merge network plus load and emit
  function automatic ctrl_word_t ucode(input logic [UPC_W-1:0] step);
    ctrl_word_t cw;
    cw = '{op: OP_NOP, hold: HOLD_NONE, jump: JUMP_ALWAYS, target: STEP_LOAD};
    unique case (step)
      STEP_LOAD:   cw = '{OP_LOAD,   HOLD_IN,   JUMP_LOAD_MORE, STEP_LOAD};
      STEP_P_INIT: cw = '{OP_P_INIT, HOLD_NONE, JUMP_NEVER,     STEP_LOAD};
      STEP_P_TEST: cw = '{OP_NOP,    HOLD_NONE, JUMP_P_END,     STEP_O_INIT};
      STEP_K_INIT: cw = '{OP_K_INIT, HOLD_NONE, JUMP_NEVER,     STEP_LOAD};
      STEP_K_TEST: cw = '{OP_NOP,    HOLD_NONE, JUMP_K_END,     STEP_P_NEXT};
      STEP_J_INIT: cw = '{OP_J_INIT, HOLD_NONE, JUMP_NEVER,     STEP_LOAD};
      STEP_J_TEST: cw = '{OP_NOP,    HOLD_NONE, JUMP_J_END,     STEP_K_NEXT};
      STEP_I_INIT: cw = '{OP_I_INIT, HOLD_NONE, JUMP_NEVER,     STEP_LOAD};
      STEP_I_TEST: cw = '{OP_NOP,    HOLD_NONE, JUMP_I_END,     STEP_J_NEXT};
      STEP_READ:   cw = '{OP_READ,   HOLD_NONE, JUMP_CROSS,     STEP_I_NEXT};
      STEP_SWAP_A: cw = '{OP_SWAP_A, HOLD_NONE, JUMP_NEVER,     STEP_LOAD};
      STEP_SWAP_B: cw = '{OP_SWAP_B, HOLD_NONE, JUMP_NEVER,     STEP_LOAD};
      STEP_I_NEXT: cw = '{OP_I_NEXT, HOLD_NONE, JUMP_ALWAYS,    STEP_I_TEST};
      STEP_J_NEXT: cw = '{OP_J_NEXT, HOLD_NONE, JUMP_ALWAYS,    STEP_J_TEST};
      STEP_K_NEXT: cw = '{OP_K_NEXT, HOLD_NONE, JUMP_ALWAYS,    STEP_K_TEST};
      STEP_P_NEXT: cw = '{OP_P_NEXT, HOLD_NONE, JUMP_ALWAYS,    STEP_P_TEST};
      STEP_O_INIT: cw = '{OP_O_INIT, HOLD_NONE, JUMP_NEVER,     STEP_LOAD};
      STEP_E_READ: cw = '{OP_E_READ, HOLD_NONE, JUMP_NEVER,     STEP_LOAD};
      STEP_EMIT:   cw = '{OP_EMIT,   HOLD_OUT,  JUMP_EMIT_MORE, STEP_E_READ};
      STEP_BACK:   cw = '{OP_NOP,    HOLD_NONE, JUMP_ALWAYS,    STEP_LOAD};
      default:     cw = '{OP_NOP,    HOLD_NONE, JUMP_ALWAYS,    STEP_LOAD};
    endcase
    return cw;
  endfunction

endpackage

>>> sv/oems_ram.sv
// oems_ram: generic RAM, one write port and two registered read ports
// no dependencies; used by odd_even_merge_sorter_unit for the value store
module oems_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> sv/odd_even_merge_sorter_unit.sv
// odd_even_merge_sorter_unit: top level, microcoded sequencer and datapath of the sorter
// depends on oems_pkg (control program, codes) and oems_ram (value store)
//
// Collects ELEMENTS signed words (a power of two), one per accepted input word, then
// sorts them ascending with a Batcher odd-even merge network and sends them out lowest
// first with their position; last marks the final word of the run. Loading accepts one
// word per cycle. The sort is run by a small program in a control store stepping a
// shared compare-exchange datapath: each compare-exchange runs the loop test, the
// two-port read, two writes through the store's single write port and the index step;
// each pair skipped by the network runs only the loop test, the read and the index step.
// Each word is emitted by a read step and an emit step, which waits while the output
// is stalled. Input is stalled from the last word of a set until the sequencer returns
// to the load step after the last sorted word has been placed in the output register.
module odd_even_merge_sorter_unit #(
  parameter int ELEMENTS    = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [oems_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [oems_pkg::DATA_W-1:0] sorted_value,
  output logic [oems_pkg::POS_W-1:0]        position,
  output logic                              last
);

  import oems_pkg::*;

  localparam int AW = $clog2(ELEMENTS);
  localparam int CW = AW + 1;
  localparam int SW = CW + 1;
  localparam logic [SW-1:0] N_S   = SW'(ELEMENTS);
  localparam logic [AW-1:0] A_TOP = AW'(ELEMENTS - 1);

  // sequencer state
  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  ctrl_word_t       cw;

  // loop indices of the network and the load / emit counters
  logic [CW-1:0] p;
  logic [CW-1:0] k;
  logic [CW-1:0] j;
  logic [CW-1:0] i;
  logic [AW-1:0] load_count;
  logic [AW-1:0] o;

  // compare-exchange datapath
  logic [SW-1:0]          addr_a;
  logic [SW-1:0]          addr_b;
  logic [SW-1:0]          jk_sum;
  logic [SW-1:0]          blk_mask;
  logic [VALUE_WIDTH-1:0] hi_val;
  logic [VALUE_WIDTH-1:0] rd_a;
  logic [VALUE_WIDTH-1:0] rd_b;
  logic                   swap;

  // store ports
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]          ram_raddr_a;

  logic hold;
  logic go;
  logic jump;

  // control store lookup
  assign cw = ucode(upc);

  // index arithmetic of the network
  assign addr_a   = SW'(i) + SW'(j);
  assign addr_b   = addr_a + SW'(k);
  assign jk_sum   = SW'(j) + SW'(k);
  assign blk_mask = ~((SW'(p) << 1) - SW'(1));
  assign swap     = $signed(rd_a) > $signed(rd_b);

  // hold decode
  always_comb begin
    unique case (cw.hold)
      HOLD_IN:  hold = !in_valid;
      HOLD_OUT: hold = out_valid && out_stall;
      default:  hold = 1'b0;
    endcase
  end

  assign go       = !hold;
  assign in_stall = (cw.hold != HOLD_IN);

  // jump decode
  always_comb begin
    unique case (cw.jump)
      JUMP_ALWAYS:    jump = 1'b1;
      JUMP_LOAD_MORE: jump = (load_count != A_TOP);
      JUMP_P_END:     jump = (SW'(p) >= N_S);
      JUMP_K_END:     jump = (k == '0);
      JUMP_J_END:     jump = (jk_sum >= N_S);
      JUMP_I_END:     jump = (i >= k) || (addr_b >= N_S);
      JUMP_CROSS:     jump = ((addr_a ^ addr_b) & blk_mask) != '0;
      JUMP_EMIT_MORE: jump = (o != A_TOP);
      default:        jump = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    if (hold) begin
      upc_next = upc;
    end else if (jump) begin
      upc_next = cw.target;
    end else begin
      upc_next = upc + UPC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= STEP_LOAD;
    end else begin
      upc <= upc_next;
    end
  end

  // store write port: loading, then the low and high halves of an exchange
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = load_count;
    ram_wdata = VALUE_WIDTH'($unsigned(value));
    if (go && cw.op == OP_LOAD) begin
      ram_we = 1'b1;
    end else if (cw.op == OP_SWAP_A) begin
      ram_we    = 1'b1;
      ram_waddr = addr_a[AW-1:0];
      ram_wdata = swap ? rd_b : rd_a;
    end else if (cw.op == OP_SWAP_B) begin
      ram_we    = 1'b1;
      ram_waddr = addr_b[AW-1:0];
      ram_wdata = hi_val;
    end
  end

  // port a follows the emit counter while emitting, else the exchange pair
  assign ram_raddr_a = (cw.op == OP_E_READ || cw.op == OP_EMIT) ? o : addr_a[AW-1:0];

  oems_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(ELEMENTS)
  ) u_store (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr_a(ram_raddr_a),
    .raddr_b(addr_b[AW-1:0]),
    .rdata_a(rd_a),
    .rdata_b(rd_b)
  );

  // index registers, stepped by the control word
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      p          <= '0;
      k          <= '0;
      j          <= '0;
      i          <= '0;
      o          <= '0;
    end else if (go) begin
      unique case (cw.op)
        OP_NOP:    ;
        OP_LOAD:   load_count <= (load_count == A_TOP) ? '0 : load_count + AW'(1);
        OP_P_INIT: p <= CW'(1);
        OP_K_INIT: k <= p;
        OP_J_INIT: j <= k & (p - CW'(1));
        OP_I_INIT: i <= '0;
        OP_READ:   ;
        OP_SWAP_A: ;
        OP_SWAP_B: ;
        OP_I_NEXT: i <= i + CW'(1);
        OP_J_NEXT: j <= j + (k << 1);
        OP_K_NEXT: k <= k >> 1;
        OP_P_NEXT: p <= p << 1;
        OP_O_INIT: o <= '0;
        OP_E_READ: ;
        OP_EMIT:   o <= o + AW'(1);
      endcase
    end
  end

  // high half of an exchange is registered for the second write
  always_ff @(posedge clk) begin
    if (cw.op == OP_SWAP_A) begin
      hi_val <= swap ? rd_a : rd_b;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && cw.op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && cw.op == OP_EMIT) begin
      sorted_value <= $signed(DATA_W'($unsigned(rd_a)));
      position     <= POS_W'(o);
      last         <= (o == A_TOP);
    end
  end

endmodule

>>> tb/testbench.sv
// testbench: self-checking bench for odd_even_merge_sorter_unit, sets of signed words in,
// sorted words out; expectations come from a plain ascending sort of each loaded set
// depends on oems_pkg (port widths) and the sorter rtl
module testbench;
  import oems_pkg::*;

  localparam int SET_SIZE   = 32;
  localparam int SET_COUNT  = 7;
  localparam int IDLE_LIMIT = 20000;
  localparam int SHOW_LIMIT = 40;

  // shapes of a random set
  typedef enum int {
    SHAPE_SCATTER,
    SHAPE_CLUSTER,
    SHAPE_RISING,
    SHAPE_FALLING,
    SHAPE_FLAT
  } set_shape_t;

  typedef struct {
    int value;
    bit drain_first;
    int gap_pct;
    int stall_pct;
  } feed_word_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
    logic                     last;
  } sorted_word_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] sorted_value;
  logic [POS_W-1:0]         position;
  logic                     last;

  feed_word_t   feed_q[$];
  sorted_word_t sorted_due[$];
  int           set_buf[SET_SIZE];
  int           fill_count = 0;
  int           stall_pct = 0;
  int           fault_count = 0;
  int           idle_cycles = 0;
  bit           word_taken = 1'b0;

  odd_even_merge_sorter_unit #(
    .ELEMENTS    (SET_SIZE),
    .VALUE_WIDTH (DATA_W)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sorted_value (sorted_value),
    .position     (position),
    .last         (last)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (fault_count < SHOW_LIMIT) begin
      $display("mismatch: %s got %0d expected %0d", what, got, want);
    end
    fault_count++;
  endtask

  task automatic queue_word(input int v, input bit drain, input int gap, input int stall);
    feed_word_t w;
    w.value       = v;
    w.drain_first = drain;
    w.gap_pct     = gap;
    w.stall_pct   = stall;
    feed_q.push_back(w);
  endtask

  // driver: words and stalls change on the falling edge
  always @(negedge clk) begin : drive
    feed_word_t nxt;
    bit         busy;
    bit         held_back;
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
      busy = in_valid && !word_taken;
      if (!busy) begin
        held_back = feed_q.size() == 0;
        if (!held_back) begin
          held_back = (feed_q[0].drain_first && sorted_due.size() != 0) ||
                      ($urandom_range(0, 99) < feed_q[0].gap_pct);
        end
        if (!held_back) begin
          nxt = feed_q.pop_front();
          value     <= nxt.value;
          in_valid  <= 1'b1;
          stall_pct = nxt.stall_pct;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: predicts on accepted input words and checks accepted results
  always @(posedge clk) begin : observe
    sorted_word_t got_w;
    sorted_word_t want_w;
    bit           result_taken;
    int           key;
    int           j;
    if (rst) begin
      fill_count  = 0;
      idle_cycles = 0;
      word_taken  = 1'b0;
    end else begin
      word_taken   = in_valid && !in_stall;
      result_taken = out_valid && !out_stall;

      // collect the set; on its last word sort it ascending and queue the results
      if (word_taken) begin
        set_buf[fill_count] = value;
        fill_count++;
        if (fill_count == SET_SIZE) begin
          fill_count = 0;
          for (int i = 1; i < SET_SIZE; i++) begin
            key = set_buf[i];
            j = i - 1;
            while (j >= 0 && set_buf[j] > key) begin
              set_buf[j + 1] = set_buf[j];
              j--;
            end
            set_buf[j + 1] = key;
          end
          for (int i = 0; i < SET_SIZE; i++) begin
            want_w.value    = set_buf[i];
            want_w.position = i[POS_W-1:0];
            want_w.last     = (i == SET_SIZE - 1);
            sorted_due.push_back(want_w);
          end
        end
      end

      // compare against the oldest expected word
      if (result_taken) begin
        got_w.value    = sorted_value;
        got_w.position = position;
        got_w.last     = last;
        if (sorted_due.size() == 0) begin
          report_mismatch("result with nothing expected, value", got_w.value, 0);
        end else begin
          want_w = sorted_due.pop_front();
          if (got_w.value !== want_w.value)
            report_mismatch("sorted_value", got_w.value, want_w.value);
          if (got_w.position !== want_w.position)
            report_mismatch("position", got_w.position, want_w.position);
          if (got_w.last !== want_w.last)
            report_mismatch("last", got_w.last, want_w.last);
        end
      end

      // watchdog on cycles with no handshake
      if (word_taken || result_taken) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("testbench: done, errors");
          $finish;
        end
      end
    end
  end

  // stimulus, phases and end of run
  initial begin : stimulus
    int         edge_values[24];
    int         gaps[SET_COUNT];
    int         stalls[SET_COUNT];
    set_shape_t shapes[SET_COUNT];
    int         v;
    edge_values = '{32'h80000000, 32'h7fffffff, 0, -1, 1, 32'h80000001, 32'h7ffffffe,
                    32'h55555555, 32'haaaaaaaa, 0, 32'h80000000, 32'h7fffffff, -1, 2, -2,
                    32'h0000ffff, 32'hffff0000, 32'h40000000, 32'hc0000000, 0, 5, 5, -5,
                    32'h00010000};
    gaps   = '{0, 55, 0, 20, 0, 0, 20};
    stalls = '{0, 0, 55, 20, 0, 55, 20};
    shapes = '{SHAPE_SCATTER, SHAPE_SCATTER, SHAPE_CLUSTER, SHAPE_RISING, SHAPE_FALLING,
               SHAPE_FLAT, SHAPE_SCATTER};

    // first set: extremes, alternating bit patterns and repeated words, topped up at random
    foreach (edge_values[i]) queue_word(edge_values[i], 1'b0, gaps[0], stalls[0]);
    for (int i = 24; i < SET_SIZE; i++) queue_word($urandom, 1'b0, gaps[0], stalls[0]);

    // random sets of several shapes; the fifth set waits for the previous run to drain
    for (int s = 1; s < SET_COUNT; s++) begin
      v = $urandom;
      if (shapes[s] == SHAPE_RISING || shapes[s] == SHAPE_FALLING)
        v = $urandom_range(0, 1 << 20) - (1 << 19);
      for (int i = 0; i < SET_SIZE; i++) begin
        case (shapes[s])
          SHAPE_SCATTER: v = $urandom;
          SHAPE_CLUSTER: v = $urandom_range(0, 6) - 3;
          SHAPE_RISING:  v = v + $urandom_range(0, 3);
          SHAPE_FALLING: v = v - $urandom_range(0, 3);
          default:       ;
        endcase
        queue_word(v, (s == 4) && (i == 0), gaps[s], stalls[s]);
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // wait for every word to go in and every result to come out
    while (feed_q.size() != 0 || in_valid || sorted_due.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (fault_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
sv/oems_pkg.sv
sv/oems_ram.sv
sv/odd_even_merge_sorter_unit.sv
tb/testbench.sv
